### rtl/bsel_pkg.sv
// Package for the backend selector: codes, widths and defaults.
package bsel_pkg;

  localparam int MaxBackendsDef = 8;
  localparam int WeightBitsDef  = 8;
  localparam int ConnBitsDef    = 16;

  localparam int ModeW  = 2;
  localparam int CountW = 4;
  localparam int TableW = 64;
  localparam int ActW   = 3;
  localparam int IdxW   = 3;
  localparam int HashW  = 32;
  localparam int RunW   = 16;
  localparam int CfgIdxW = 2;

  localparam logic [TableW-1:0] TableReset = 64'h0101010101010101;

  typedef enum logic [ModeW-1:0] {
    MODE_RR   = 2'd0,
    MODE_WRR  = 2'd1,
    MODE_LC   = 2'd2,
    MODE_HASH = 2'd3
  } mode_t;

  typedef enum logic [ActW-1:0] {
    ACT_PICK   = 3'd0,
    ACT_OPEN   = 3'd1,
    ACT_CLOSE  = 3'd2,
    ACT_DOWN   = 3'd3,
    ACT_UP     = 3'd4
  } action_t;

  localparam logic [CfgIdxW-1:0] REG_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_COUNT  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WEIGHT = 2'd2;

  // Control from the sequencer to the modulo unit, and its status back.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### rtl/bsel_mod.sv
// Bit-serial remainder of the client hash by the healthy count.
module bsel_mod #(
  parameter int MAX_BACKENDS = bsel_pkg::MaxBackendsDef
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  bsel_pkg::div_ctl_t                        ctl,
  input  logic [bsel_pkg::HashW-1:0]                dividend,
  input  logic [$clog2(MAX_BACKENDS+1)-1:0]         divisor,
  output bsel_pkg::div_sts_t                        sts,
  output logic [$clog2(MAX_BACKENDS+1)-1:0]         remainder
);
  import bsel_pkg::*;

  localparam int DW = $clog2(MAX_BACKENDS + 1);
  localparam int BW = $clog2(HashW + 1);

  logic [HashW-1:0] shreg;
  logic [DW-1:0]    dsor;
  logic [DW:0]      rem;
  logic [BW-1:0]    bits_left;
  logic             busy;
  logic             done;
  logic [DW:0]      trial;

  // one quotient bit per cycle, restoring style
  always_comb begin
    trial = {rem[DW-1:0], shreg[HashW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bits_left <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        bits_left <= BW'(HashW);
      end else if (busy) begin
        bits_left <= bits_left - 1'b1;
        if (bits_left == BW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      shreg <= dividend;
      dsor  <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[HashW-2:0], 1'b0};
      if (trial >= {1'b0, dsor}) rem <= trial - {1'b0, dsor};
      else rem <= trial;
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign remainder = rem[DW-1:0];

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("modulo done while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> rem < {1'b0, dsor})
    else $error("remainder not reduced");
  assert property (@(posedge clk) disable iff (rst) ctl.start |=> busy)
    else $error("modulo did not start");

endmodule

### rtl/backend_selector.sv
// Backend selector top level: sequencer, backend scan and state.
//
//  channel | signals                                    | direction
//  in      | in_valid, in_stall, action, backend_index, client_hash | to block
//  out     | out_valid, out_stall, found, chosen_backend  | from block
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | to block
//
// Each accepted item is finished before the next is taken. Least connections
// scans the backends in use; round robin passes S_WRAP first, weighted ends in
// S_SUB, hash counts the healthy ones, runs the modulo, and scans again unless
// none is healthy. Round robin subtracts the count from a pointer past a shrunk
// count. rst is synchronous; all but act_r and hash_r return to reset values.
// in_stall is high until the item is done; a result waits under out_stall.
module backend_selector #(
  parameter int MAX_BACKENDS = bsel_pkg::MaxBackendsDef,
  parameter int WEIGHT_BITS  = bsel_pkg::WeightBitsDef,
  parameter int CONN_BITS    = bsel_pkg::ConnBitsDef
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bsel_pkg::ActW-1:0]       action,
  input  logic [bsel_pkg::IdxW-1:0]       backend_index,
  input  logic [bsel_pkg::HashW-1:0]      client_hash,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [bsel_pkg::IdxW-1:0]       chosen_backend,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsel_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bsel_pkg::TableW-1:0]     cfg_data
);
  import bsel_pkg::*;

  localparam int NB = MAX_BACKENDS;
  localparam int IW = $clog2(NB);
  localparam int CW = $clog2(NB + 1);
  localparam logic [RunW-1:0] RunMax = {1'b0, {(RunW-1){1'b1}}};
  localparam logic [RunW-1:0] RunMin = {1'b1, {(RunW-1){1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_SUB   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_HSCAN = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_WRAP  = 7'b1000000
  } state_t;

  state_t state;

  logic [ModeW-1:0]  mode;
  logic [CountW-1:0] count_reg;
  logic [TableW-1:0] wtable;
  logic [IW-1:0]     rot;
  logic [NB-1:0]     healthy;
  logic [RunW-1:0]   runw [NB];
  logic [CONN_BITS-1:0] conns [NB];

  logic [ActW-1:0]  act_r;
  logic [HashW-1:0] hash_r;

  logic [CW-1:0]    n_act;
  logic [IW-1:0]    scan_i;
  logic [CW-1:0]    step;
  logic             have;
  logic [IW-1:0]    sel;
  logic signed [RunW:0] best;
  logic [CONN_BITS-1:0] best_c;
  logic [RunW+CW:0] total;
  logic [CW-1:0]    hcnt;
  logic [CW-1:0]    seen;

  div_ctl_t         dctl;
  div_sts_t         dsts;
  logic [CW-1:0]    drem;

  logic [WEIGHT_BITS-1:0] wcur;
  logic signed [RunW+1:0] rsum;
  logic [RunW-1:0]  rsat;
  logic signed [RunW+CW+2:0] rdiff;
  logic [RunW-1:0]  dsat;
  logic             hcur;

  bsel_mod #(.MAX_BACKENDS(MAX_BACKENDS)) u_mod (
    .clk, .rst, .ctl(dctl), .dividend(hash_r), .divisor(hcnt),
    .sts(dsts), .remainder(drem)
  );

  always_comb begin
    if (int'(count_reg) > NB) n_act = CW'(NB);
    else n_act = CW'(count_reg);
  end

  // weight of the scanned backend; bits past the table read zero
  always_comb begin
    wcur = '0;
    for (int b = 0; b < WEIGHT_BITS; b++) begin
      if (int'(scan_i) * WEIGHT_BITS + b < TableW)
        wcur[b] = wtable[int'(scan_i) * WEIGHT_BITS + b];
    end
  end

  assign hcur = healthy[scan_i];
  assign rsum = (RunW+2)'(signed'(runw[scan_i])) + (RunW+2)'(signed'({1'b0, wcur}));
  always_comb begin
    if (rsum > (RunW+2)'(signed'(RunMax))) rsat = RunMax;
    else if (rsum < (RunW+2)'(signed'(RunMin))) rsat = RunMin;
    else rsat = rsum[RunW-1:0];
  end
  assign rdiff = (RunW+CW+3)'(signed'(runw[sel])) - (RunW+CW+3)'(signed'({1'b0, total}));
  always_comb begin
    if (rdiff < (RunW+CW+3)'(signed'(RunMin))) dsat = RunMin;
    else dsat = rdiff[RunW-1:0];
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign dctl.start = (state == S_DIV) && (hcnt != '0) && !dsts.busy && !dsts.done &&
                      (step == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= MODE_RR;
      count_reg <= CountW'(1);
      wtable <= TableReset;
      rot <= '0;
      healthy <= '1;
      out_valid <= 1'b0;
      found <= 1'b0;
      chosen_backend <= '0;
      for (int k = 0; k < NB; k++) begin
        runw[k] <= '0;
        conns[k] <= '0;
      end
      scan_i <= '0; step <= '0; have <= 1'b0; sel <= '0;
      best <= '0; best_c <= '0; total <= '0; hcnt <= '0; seen <= '0;
    end else begin
      if (out_valid && !out_stall && !(state == S_OUT && act_r == ACT_PICK))
        out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE: begin
            mode <= cfg_data[ModeW-1:0];
            rot <= '0;
            if (cfg_data[ModeW-1:0] == MODE_WRR)
              for (int k = 0; k < NB; k++) runw[k] <= '0;
          end
          REG_COUNT: count_reg <= cfg_data[CountW-1:0];
          REG_WEIGHT: wtable <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            act_r <= action; hash_r <= client_hash;
            have <= 1'b0; total <= '0; hcnt <= '0; seen <= '0; step <= '0;
            scan_i <= '0;
            if (action == ACT_PICK) begin
              if (n_act == '0) begin
                state <= S_OUT;
              end else if (mode == MODE_RR) begin
                state <= S_WRAP;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              if (CW'(backend_index) < n_act) begin
                case (action)
                  ACT_OPEN: if (conns[backend_index] != '1)
                    conns[backend_index] <= conns[backend_index] + 1'b1;
                  ACT_CLOSE: if (conns[backend_index] != '0)
                    conns[backend_index] <= conns[backend_index] - 1'b1;
                  ACT_DOWN: healthy[backend_index] <= 1'b0;
                  ACT_UP:   healthy[backend_index] <= 1'b1;
                  default: ;
                endcase
              end
            end
          end
        end
        S_WRAP: begin
          // start is rot mod n; rot stays below n unless the count shrank
          if (CW'(rot) >= n_act) begin
            rot <= IW'(CW'(rot) - n_act);
          end else begin
            scan_i <= rot;
            rot <= (CW'(rot) + 1'b1 >= n_act) ? '0 : IW'(CW'(rot) + 1'b1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_i <= (CW'(scan_i) + 1'b1 >= n_act) ? '0 : IW'(CW'(scan_i) + 1'b1);
          case (mode)
            MODE_RR: if (hcur && !have) begin
              have <= 1'b1; sel <= scan_i;
            end
            MODE_WRR: if (hcur) begin
              total <= total + (RunW+CW+1)'(wcur);
              runw[scan_i] <= rsat;
              if (!have || (RunW+1)'(signed'(rsat)) > best) begin
                have <= 1'b1; sel <= scan_i; best <= (RunW+1)'(signed'(rsat));
              end
            end
            MODE_LC: if (hcur && (!have || conns[scan_i] < best_c)) begin
              have <= 1'b1; sel <= scan_i; best_c <= conns[scan_i];
            end
            default: if (hcur) hcnt <= hcnt + 1'b1;
          endcase
          if (step + 1'b1 == n_act) begin
            step <= '0;
            case (mode)
              MODE_WRR: state <= S_SUB;
              MODE_HASH: state <= S_DIV;
              default: state <= S_OUT;
            endcase
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SUB: begin
          if (have) runw[sel] <= dsat;
          state <= S_OUT;
        end
        S_DIV: begin
          if (hcnt == '0) state <= S_OUT;
          else if (dsts.done) begin
            state <= S_HSCAN; scan_i <= '0; step <= '0;
          end
        end
        S_HSCAN: begin
          step <= step + 1'b1;
          scan_i <= IW'(CW'(scan_i) + 1'b1);
          if (hcur && !have) begin
            if (seen == drem) begin
              have <= 1'b1; sel <= scan_i;
            end
            seen <= seen + 1'b1;
          end
          if (step + 1'b1 == n_act) state <= S_OUT;
        end
        S_OUT: begin
          if (act_r == ACT_PICK) begin
            if (!out_valid || !out_stall) begin
              out_valid <= 1'b1;
              found <= have;
              chosen_backend <= have ? IdxW'(sel) : '0;
              state <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE && in_valid && action != ACT_PICK) state <= S_OUT;
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("accepting while busy");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> chosen_backend == '0)
    else $error("index set without a find");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && mode == MODE_RR && count_reg != '0) |-> CW'(rot) < CW'(NB))
    else $error("pointer out of range");

endmodule

### tb/testbench.sv
// Testbench for backend_selector: directed and random picks against a local predictor.
`timescale 1ns / 100ps

module testbench;
  import bsel_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam logic [ActW-1:0] ACT_BAD5 = 3'd5;
  localparam logic [ActW-1:0] ACT_BAD6 = 3'd6;
  localparam logic [ActW-1:0] ACT_BAD7 = 3'd7;
  localparam int HoldCycles = 300;
  localparam int WatchLimit = 4000;
  localparam int ConnMax = 65535;

  typedef struct packed {
    logic       found;
    logic [2:0] chosen;
  } pick_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [ActW-1:0] action;
  logic [IdxW-1:0] backend_index;
  logic [HashW-1:0] client_hash;
  logic out_valid, out_stall;
  logic found;
  logic [IdxW-1:0] chosen_backend;
  logic cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TableW-1:0] cfg_data;

  backend_selector dut (.*);

  // predictor state
  mode_t       sel_mode;
  int          sel_count;
  logic [63:0] weights;
  int          rr_ptr;
  int          run_w[8];
  int          conns[8];
  logic [7:0]  healthy;
  pick_t       picks_due[$];

  int  errors = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;
  bit  gaps_on = 1;
  int  stall_pct = 30;
  bit  hold_req = 0;
  int  hold_cnt = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void predict_item(logic [2:0] a, logic [2:0] bi, logic [31:0] h);
    int n, start, k, total, w, sel, cnt, target, seen;
    bit have;
    pick_t r;
    n = (sel_count > 8) ? 8 : sel_count;
    have = 0;
    sel = 0;
    if (a == ACT_PICK) begin
      if (n != 0) begin
        case (sel_mode)
          MODE_RR: begin
            start = rr_ptr % n;
            rr_ptr = (start + 1) % n;
            for (int i = 0; i < n; i++) begin
              k = (start + i) % n;
              if (!have && healthy[k]) begin
                sel = k;
                have = 1;
              end
            end
          end
          MODE_WRR: begin
            total = 0;
            for (int i = 0; i < n; i++) begin
              if (healthy[i]) begin
                w = weights[i*8 +: 8];
                total += w;
                run_w[i] = sat16(run_w[i] + w);
                if (!have || run_w[i] > run_w[sel]) begin
                  sel = i;
                  have = 1;
                end
              end
            end
            if (have) run_w[sel] = sat16(run_w[sel] - total);
          end
          MODE_LC: begin
            for (int i = 0; i < n; i++) begin
              if (healthy[i] && (!have || conns[i] < conns[sel])) begin
                sel = i;
                have = 1;
              end
            end
          end
          default: begin
            cnt = 0;
            seen = 0;
            for (int i = 0; i < n; i++) if (healthy[i]) cnt++;
            if (cnt != 0) begin
              target = int'(longint'(h) % cnt);
              for (int i = 0; i < n; i++) begin
                if (healthy[i]) begin
                  if (!have && seen == target) begin
                    sel = i;
                    have = 1;
                  end
                  seen++;
                end
              end
            end
          end
        endcase
      end
      r.found = have;
      r.chosen = have ? sel[2:0] : 3'd0;
      picks_due = {picks_due, r};
    end else if (int'(bi) < n) begin
      case (a)
        ACT_OPEN:  if (conns[bi] < ConnMax) conns[bi]++;
        ACT_CLOSE: if (conns[bi] > 0) conns[bi]--;
        ACT_DOWN:  healthy[bi] = 1'b0;
        ACT_UP:    healthy[bi] = 1'b1;
        default: ;
      endcase
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    pick_t e;
    if (!rst && out_valid && !out_stall) begin
      if (picks_due.size() == 0) begin
        $display("%0t: unexpected result found=%0d chosen=%0d", $time, found,
                 chosen_backend);
        errors++;
      end else begin
        e = picks_due.pop_front();
        if (found !== e.found) begin
          $display("%0t: found expected %0d actual %0d", $time, e.found, found);
          errors++;
        end
        if (chosen_backend !== e.chosen) begin
          $display("%0t: chosen_backend expected %0d actual %0d", $time, e.chosen,
                   chosen_backend);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
      hold_cnt++;
      if (hold_cnt >= HoldCycles) begin
        hold_cnt = 0;
        hold_req = 0;
      end
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] a, logic [2:0] bi, logic [31:0] h);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    in_valid <= 1'b1;
    action <= a;
    backend_index <= bi;
    client_hash <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(a, bi, h);
  endtask

  // lower valid and let all work finish before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (picks_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE: begin
        sel_mode = mode_t'(val[1:0]);
        rr_ptr = 0;
        if (sel_mode == MODE_WRR) foreach (run_w[i]) run_w[i] = 0;
      end
      REG_COUNT: sel_count = val[3:0];
      REG_WEIGHT: weights = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(ACT_PICK, 3'd5, 32'h0);
    drain();
    write_reg(REG_COUNT, 64'd8);
    write_reg(REG_WEIGHT, 64'h0807060504030201);
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    repeat (3) send_item(ACT_PICK, 3'd0, 32'h0);
    send_item(ACT_DOWN, 3'd1, 32'h0);
    send_item(ACT_PICK, 3'd7, 32'h0);
    send_item(ACT_CLOSE, 3'd3, 32'h0);
    send_item(ACT_OPEN, 3'd0, 32'h0);
    send_item(ACT_BAD5, 3'd0, 32'h0);
    send_item(ACT_BAD6, 3'd7, 32'hFFFF_FFFF);
    send_item(ACT_BAD7, 3'd2, 32'h0);
    drain();
    write_reg(REG_MODE, {62'h0, MODE_WRR});
    repeat (3) send_item(ACT_PICK, 3'd0, 32'h0);
    drain();
    write_reg(REG_MODE, {62'h0, MODE_LC});
    send_item(ACT_PICK, 3'd0, 32'h0);
    drain();
    write_reg(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_PICK, 3'd0, 32'h0);
    send_item(ACT_PICK, 3'd0, 32'hFFFF_FFFF);
    send_item(ACT_UP, 3'd1, 32'h0);
    drain();
    write_reg(REG_COUNT, 64'd3);
    send_item(ACT_DOWN, 3'd6, 32'h0);
    send_item(ACT_PICK, 3'd0, 32'h1234_5678);
    drain();
    write_reg(REG_COUNT, 64'd0);
    send_item(ACT_PICK, 3'd0, 32'h0);
    send_item(ACT_OPEN, 3'd0, 32'h0);
    drain();
    write_reg(REG_COUNT, 64'd15);
    for (int i = 0; i < 8; i++) send_item(ACT_DOWN, i[2:0], 32'h0);
    send_item(ACT_PICK, 3'd0, 32'h0);
    for (int i = 0; i < 8; i++) send_item(ACT_UP, i[2:0], 32'h0);
    drain();
  endtask

  // open and close on one backend, then check it from LC
  task automatic test_conn_limits();
    gaps_on = 0;
    write_reg(REG_COUNT, 64'd8);
    write_reg(REG_MODE, {62'h0, MODE_LC});
    for (int i = 0; i < 12; i++) send_item(ACT_OPEN, 3'd7, 32'h0);
    send_item(ACT_CLOSE, 3'd7, 32'h0);
    send_item(ACT_OPEN, 3'd7, 32'h0);
    for (int i = 0; i < 7; i++) send_item(ACT_DOWN, i[2:0], 32'h0);
    send_item(ACT_PICK, 3'd0, 32'h0);
    for (int i = 0; i < 7; i++) send_item(ACT_UP, i[2:0], 32'h0);
    send_item(ACT_PICK, 3'd0, 32'h0);
    drain();
    gaps_on = 1;
  endtask

  task automatic test_long_hold();
    gaps_on = 0;
    hold_req = 1;
    repeat (12) send_item(ACT_PICK, 3'd0, $urandom);
    drain();
    gaps_on = 1;
  endtask

  task automatic random_items(int num);
    int r;
    logic [2:0] a;
    logic [31:0] h;
    for (int i = 0; i < num; i++) begin
      r = $urandom_range(99);
      if (r < 50) a = ACT_PICK;
      else if (r < 65) a = ACT_OPEN;
      else if (r < 77) a = ACT_CLOSE;
      else if (r < 86) a = ACT_DOWN;
      else if (r < 96) a = ACT_UP;
      else a = 3'($urandom_range(5, 7));
      r = $urandom_range(9);
      h = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
      send_item(a, 3'($urandom_range(7)), h);
    end
  endtask

  task automatic test_random();
    logic [63:0] w;
    int r;
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      stall_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 30 : 75;
      gaps_on = (ph % 4 != 3);
      r = $urandom_range(3);
      w = (r == 0) ? 64'h0 : (r == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
      write_reg(REG_WEIGHT, w);
      write_reg(REG_COUNT, (ph == 4) ? 64'd0 : (ph == 5) ? 64'd15 : (ph == 6) ? 64'd8 :
                {60'h0, 4'($urandom_range(1, 15))});
      write_reg(REG_MODE, {62'h0, 2'(ph % 4)});
      random_items(90);
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_PICK;
    backend_index = '0;
    client_hash = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    sel_mode = MODE_RR;
    sel_count = 1;
    weights = TableReset;
    rr_ptr = 0;
    healthy = 8'hFF;
    foreach (run_w[i]) begin
      run_w[i] = 0;
      conns[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_long_hold();
    test_random();
    test_conn_limits();
    drain();
    if (picks_due.size() != 0) errors++;
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### files.f
rtl/bsel_pkg.sv
rtl/bsel_mod.sv
rtl/backend_selector.sv
tb/testbench.sv
